@@ design/lrukv_pkg.sv @@
`timescale 1ns / 1ps
package lrukv_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  typedef logic [KEY_W-1:0]          key_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // Request operation
  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // Value returned by a get that misses
  localparam value_t MISS_VALUE = value_t'(-1);

endpackage

@@ design/lrukv_req_if.sv @@
`timescale 1ns / 1ps
interface lrukv_req_if import lrukv_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  key_t   lookup_key;
  value_t store_value;

  modport source (output valid, cmd, lookup_key, store_value, input ready);
  modport sink   (input valid, cmd, lookup_key, store_value, output ready);
endinterface

@@ design/lrukv_rsp_if.sv @@
`timescale 1ns / 1ps
interface lrukv_rsp_if import lrukv_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  value_t read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

@@ design/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// A get first sweeps the entry memory to search it; a hitting get, and every put, then
// makes a second, rank read-modify-write sweep over it, which a missing get skips.
// One request at a time: the next is taken only once the current one is done. A response
// still waiting for its ready holds the next get in its last step. Reset (rst, synchronous):
// all entries invalid, occupancy zero, capacity min(16, MAX_ENTRIES). A capacity write
// clears the store.
module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  lrukv_req_if.sink        req,
  lrukv_rsp_if.source      rsp
);

  localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W     = $clog2(MAX_ENTRIES + 1);
  localparam int RESET_CAP = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;

  localparam idx_t LAST_IDX = idx_t'(MAX_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_SEARCH     = 5'b00010,
    S_SEARCH_END = 5'b00100,
    S_UPDATE     = 5'b01000,
    S_FINISH     = 5'b10000
  } state_t;

  state_t state;
  idx_t   cnt;

  // Entry storage
  key_t   key_mem   [MAX_ENTRIES];
  value_t value_mem [MAX_ENTRIES];
  idx_t   rank_mem  [MAX_ENTRIES];
  key_t   key_rd;
  value_t value_rd;
  idx_t   rank_rd;
  logic   rd_vld;
  idx_t   rd_idx;

  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] valid_ins;
  occ_t                   occupancy;
  occ_t                   cap_eff;

  // Latched request
  cmd_t   req_cmd;
  key_t   req_key;
  value_t req_val;

  // Search results
  logic   hit_found;
  idx_t   hit_slot;
  idx_t   hit_rank;
  value_t hit_value;
  logic   vic_found;
  idx_t   vic_slot;
  logic   free_found;
  idx_t   free_slot;

  // Response register
  logic   rsp_vld;
  logic   rsp_hit;
  value_t rsp_value;

  logic   req_acc;
  logic   search_cmp;
  logic   wb_phase;
  logic   cur_match;
  logic   is_put;
  logic   do_insert;
  logic   evict;
  idx_t   ins_slot;
  logic   fin_go;
  logic   wb_en;
  idx_t   rank_new;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;

  assign rsp.valid      = rsp_vld;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;

  // Decision logic
  always_comb begin
    search_cmp = rd_vld && (state == S_SEARCH || state == S_SEARCH_END);
    wb_phase   = rd_vld && (state == S_UPDATE || state == S_FINISH);
    cur_match  = search_cmp && valid[rd_idx] && (key_rd == req_key);
    is_put     = (req_cmd == CMD_PUT);
    do_insert  = is_put && !hit_found;
    evict      = do_insert && (occupancy >= cap_eff);
    ins_slot   = (evict && (!free_found || vic_slot < free_slot)) ? vic_slot : free_slot;
    fin_go     = is_put || !rsp_vld || rsp.ready;
  end

  // Valid bits after an insert: victim dropped, new slot taken
  always_comb begin
    valid_ins = valid;
    if (evict) begin
      valid_ins[vic_slot] = 1'b0;
    end
    valid_ins[ins_slot] = 1'b1;
  end

  // New rank for the entry coming back from the update read
  always_comb begin
    wb_en    = 1'b0;
    rank_new = rank_rd;
    if (wb_phase) begin
      if (hit_found) begin
        if (rd_idx == hit_slot) begin
          wb_en    = 1'b1;
          rank_new = '0;
        end else if (valid[rd_idx] && rank_rd < hit_rank) begin
          wb_en    = 1'b1;
          rank_new = rank_rd + idx_t'(1);
        end
      end else begin
        if (rd_idx == ins_slot) begin
          wb_en    = 1'b1;
          rank_new = '0;
        end else if (valid[rd_idx] && !(evict && rd_idx == vic_slot)) begin
          wb_en    = 1'b1;
          rank_new = rank_rd + idx_t'(1);
        end
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SEARCH) || (state == S_UPDATE);
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (req_acc) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= S_SEARCH_END;
          end else begin
            cnt <= cnt + idx_t'(1);
          end
        end
        S_SEARCH_END: begin
          if (!is_put && !(hit_found || cur_match)) begin
            state <= S_FINISH;
          end else begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= S_FINISH;
          end else begin
            cnt <= cnt + idx_t'(1);
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request latch and read pipeline index
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (req_acc) begin
      req_cmd <= req.cmd;
      req_key <= req.lookup_key;
      req_val <= req.store_value;
    end
  end

  // Search sweep: first match, eviction victim, lowest free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (req_acc) begin
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (search_cmp) begin
      if (cur_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= rd_idx;
        hit_rank  <= rank_rd;
        hit_value <= value_rd;
      end
      if (valid[rd_idx] && occ_t'(rank_rd) == occupancy - occ_t'(1) && !vic_found) begin
        vic_found <= 1'b1;
        vic_slot  <= rd_idx;
      end
      if (!valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx;
      end
    end
  end

  // Entry memories: sweep reads registered; rank writes in update sweep, key/value at end
  always_ff @(posedge clk) begin
    key_rd   <= key_mem[cnt];
    value_rd <= value_mem[cnt];
    rank_rd  <= rank_mem[cnt];
    if (wb_en) begin
      rank_mem[rd_idx] <= rank_new;
    end
    if (state == S_FINISH && fin_go && do_insert) begin
      key_mem[ins_slot] <= req_key;
    end
    if (state == S_FINISH && fin_go && is_put) begin
      value_mem[hit_found ? hit_slot : ins_slot] <= req_val;
    end
  end

  // Valid bits, occupancy and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      cap_eff   <= occ_t'(RESET_CAP);
    end else if (cfg_wr_en) begin
      valid     <= '0;
      occupancy <= '0;
      if (cfg_wr_data == '0) begin
        cap_eff <= occ_t'(1);
      end else if (32'(cfg_wr_data) > 32'(MAX_ENTRIES)) begin
        cap_eff <= occ_t'(MAX_ENTRIES);
      end else begin
        cap_eff <= occ_t'(cfg_wr_data);
      end
    end else if (state == S_FINISH && fin_go && do_insert) begin
      valid <= valid_ins;
      if (!evict) begin
        occupancy <= occupancy + occ_t'(1);
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (state == S_FINISH && fin_go && !is_put) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && fin_go && !is_put) begin
      rsp_hit   <= hit_found;
      rsp_value <= hit_found ? hit_value : MISS_VALUE;
    end
  end

  // Checks
  a_occ_le_cap: assert property (@(posedge clk) disable iff (rst)
    occupancy <= cap_eff)
    else $error("occupancy above capacity");

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occupancy))
    else $error("occupancy does not match valid bits");

  a_slot_known: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && do_insert) |-> (evict ? vic_found : free_found))
    else $error("insert without victim or free slot");

  a_rsp_from_get: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_vld) |-> $past(state == S_FINISH && req_cmd == CMD_GET))
    else $error("response not caused by a get");

endmodule
